>>> sv/uart_dual_byte_ring_buffer_assert.svh
// Assertion macros for the ring buffer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef UART_DUAL_BYTE_RING_BUFFER_ASSERT_SVH
`define UART_DUAL_BYTE_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UDBRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udbrb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UDBRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udbrb: next-cycle check failed");

`endif

>>> sv/udbrb_pkg.sv
// Package for the dual byte ring buffer: queue sizing, item codes, pointer math.
// Used by the channel interfaces, the top level and the testbench.
`default_nettype none

package udbrb_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_CNT_W   = 9;
    localparam int BYTE_W      = 8;
    localparam int MODE_W      = 3;
    localparam int FLAGS_W     = 2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [CNT_W:0]   sum_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINE_RX  = 3'd0,
        MODE_HOST_RD  = 3'd1,
        MODE_HOST_WR  = 3'd2,
        MODE_LINE_TX  = 3'd3,
        MODE_FLUSH_RX = 3'd4,
        MODE_REINIT   = 3'd5
    } mode_t;

    localparam int FLAG_LINE_OVR  = 0;
    localparam int FLAG_QUEUE_OVR = 1;

    // Ring index base + off, where off never exceeds the queue depth.
    function automatic ptr_t wrap_add(ptr_t base, cnt_t off);
        sum_t s;
        s = sum_t'(base) + sum_t'(off);
        if (s >= sum_t'(QUEUE_DEPTH))
        begin
            s = s - sum_t'(QUEUE_DEPTH);
        end
        return ptr_t'(s);
    endfunction

endpackage

`default_nettype wire

>>> sv/udbrb_in_if.sv
// Request channel of the ring buffer: valid/ready plus one item's fields.
// Depends on udbrb_pkg for field widths.
`default_nettype none

interface udbrb_in_if;
    logic                          valid;
    logic                          ready;
    logic [udbrb_pkg::MODE_W-1:0]  mode;
    logic [udbrb_pkg::BYTE_W-1:0]  data_byte;
    logic                          line_overrun;

    modport source (output valid, output mode, output data_byte, output line_overrun,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input line_overrun,
                    output ready);
endinterface

`default_nettype wire

>>> sv/udbrb_out_if.sv
// Result channel of the ring buffer: valid/ready plus one result's fields.
// Depends on udbrb_pkg for field widths.
`default_nettype none

interface udbrb_out_if;
    logic                             valid;
    logic                             ready;
    logic [udbrb_pkg::BYTE_W-1:0]     data_out;
    logic                             data_valid;
    logic                             accepted;
    logic [udbrb_pkg::OUT_CNT_W-1:0]  rx_count;
    logic [udbrb_pkg::OUT_CNT_W-1:0]  tx_free;
    logic [udbrb_pkg::FLAGS_W-1:0]    error_flags;

    modport source (output valid, output data_out, output data_valid, output accepted,
                    output rx_count, output tx_free, output error_flags, input ready);
    modport sink   (input valid, input data_out, input data_valid, input accepted,
                    input rx_count, input tx_free, input error_flags, output ready);
endinterface

`default_nettype wire

>>> sv/udbrb_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; instanced once per byte queue.
`default_nettype none

module udbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // When enabled, write on we, otherwise register the addressed word.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/uart_dual_byte_ring_buffer.sv
// Dual byte ring buffer between a serial line and a host.
// Request channel req carries mode, data_byte and line_overrun; every accepted
// request yields exactly one result on rsp with the popped byte (if any), the
// store flag, the receive count, the transmit free space and sticky flags.
// Each queue is one QUEUE_DEPTH x 8 RAM with a registered read port.
// Pushes, flushes, reinit, spare codes and pops of an empty queue finish in
// the accept cycle: the result is valid the next cycle and a new request can
// be taken every cycle while rsp.ready is high. A pop that hits data first
// goes through S_READ for the RAM read; req.ready is low in S_READ.
// The result sits in an output register; the next request is taken in the
// same cycle that the waiting result transfers, so a stalled rsp.ready holds
// the result and blocks req until it is taken.
// Reset empties both queues, zeroes heads and sticky flags and drops any
// pending result; queue contents are not cleared and need no clearing pass.
`default_nettype none

`include "uart_dual_byte_ring_buffer_assert.svh"

module uart_dual_byte_ring_buffer (
    input wire logic clk,
    input wire logic rst_n,
    udbrb_in_if.sink   req,
    udbrb_out_if.source rsp
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;

    udbrb_pkg::ptr_t rx_head_reg, rx_head_next;
    udbrb_pkg::cnt_t rx_fill_reg, rx_fill_next;
    udbrb_pkg::ptr_t tx_head_reg, tx_head_next;
    udbrb_pkg::cnt_t tx_fill_reg, tx_fill_next;
    logic [udbrb_pkg::FLAGS_W-1:0] flags_reg, flags_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              sel_tx_reg, sel_tx_next;
    logic [udbrb_pkg::BYTE_W-1:0]      data_out_reg, data_out_next;
    logic                              data_valid_reg, data_valid_next;
    logic                              accepted_reg, accepted_next;
    logic [udbrb_pkg::OUT_CNT_W-1:0]   rx_count_reg, rx_count_next;
    logic [udbrb_pkg::OUT_CNT_W-1:0]   tx_free_reg, tx_free_next;
    logic [udbrb_pkg::FLAGS_W-1:0]     err_reg, err_next;

    logic accept;
    logic pop_hit;
    logic rx_full, rx_empty, tx_full, tx_empty;

    logic                          rx_en, rx_we, tx_en, tx_we;
    udbrb_pkg::ptr_t               rx_addr, tx_addr;
    logic [udbrb_pkg::BYTE_W-1:0]  rx_rdata, tx_rdata;

    function automatic udbrb_pkg::cnt_t cnt_one();
        return udbrb_pkg::cnt_t'(1);
    endfunction

    // Take a request only when idle and the output register is free this edge.
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rx_full  = (rx_fill_reg == udbrb_pkg::CNT_W'(udbrb_pkg::QUEUE_DEPTH));
    assign rx_empty = (rx_fill_reg == '0);
    assign tx_full  = (tx_fill_reg == udbrb_pkg::CNT_W'(udbrb_pkg::QUEUE_DEPTH));
    assign tx_empty = (tx_fill_reg == '0);

    // Decode the request: pointer updates, RAM access, status for the result.
    always_comb
    begin
        state_next      = state_reg;
        rx_head_next    = rx_head_reg;
        rx_fill_next    = rx_fill_reg;
        tx_head_next    = tx_head_reg;
        tx_fill_next    = tx_fill_reg;
        flags_next      = flags_reg;
        out_valid_next  = out_valid_reg;
        sel_tx_next     = sel_tx_reg;
        data_out_next   = data_out_reg;
        data_valid_next = data_valid_reg;
        accepted_next   = accepted_reg;
        rx_count_next   = rx_count_reg;
        tx_free_next    = tx_free_reg;
        err_next        = err_reg;
        pop_hit         = 1'b0;

        rx_en   = 1'b0;
        rx_we   = 1'b0;
        rx_addr = rx_head_reg;
        tx_en   = 1'b0;
        tx_we   = 1'b0;
        tx_addr = tx_head_reg;

        // Drop a result once it transfers.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    accepted_next = 1'b0;
                    unique case (req.mode)
                        udbrb_pkg::MODE_LINE_RX:
                        begin
                            if (req.line_overrun)
                            begin
                                flags_next[udbrb_pkg::FLAG_LINE_OVR] = 1'b1;
                            end
                            if (rx_full)
                            begin
                                flags_next[udbrb_pkg::FLAG_QUEUE_OVR] = 1'b1;
                            end
                            else
                            begin
                                rx_en         = 1'b1;
                                rx_we         = 1'b1;
                                rx_addr       = udbrb_pkg::wrap_add(rx_head_reg, rx_fill_reg);
                                rx_fill_next  = rx_fill_reg + cnt_one();
                                accepted_next = 1'b1;
                            end
                        end
                        udbrb_pkg::MODE_HOST_RD:
                        begin
                            if (!rx_empty)
                            begin
                                rx_en        = 1'b1;
                                pop_hit      = 1'b1;
                                sel_tx_next  = 1'b0;
                                rx_head_next = udbrb_pkg::wrap_add(rx_head_reg, cnt_one());
                                rx_fill_next = rx_fill_reg - cnt_one();
                            end
                        end
                        udbrb_pkg::MODE_HOST_WR:
                        begin
                            if (!tx_full)
                            begin
                                tx_en         = 1'b1;
                                tx_we         = 1'b1;
                                tx_addr       = udbrb_pkg::wrap_add(tx_head_reg, tx_fill_reg);
                                tx_fill_next  = tx_fill_reg + cnt_one();
                                accepted_next = 1'b1;
                            end
                        end
                        udbrb_pkg::MODE_LINE_TX:
                        begin
                            if (!tx_empty)
                            begin
                                tx_en        = 1'b1;
                                pop_hit      = 1'b1;
                                sel_tx_next  = 1'b1;
                                tx_head_next = udbrb_pkg::wrap_add(tx_head_reg, cnt_one());
                                tx_fill_next = tx_fill_reg - cnt_one();
                            end
                        end
                        udbrb_pkg::MODE_FLUSH_RX:
                        begin
                            rx_head_next = '0;
                            rx_fill_next = '0;
                        end
                        udbrb_pkg::MODE_REINIT:
                        begin
                            rx_head_next = '0;
                            rx_fill_next = '0;
                            tx_head_next = '0;
                            tx_fill_next = '0;
                            flags_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    // Load status now; a pop fills in the byte after the read.
                    data_out_next   = '0;
                    data_valid_next = pop_hit;
                    rx_count_next   = udbrb_pkg::OUT_CNT_W'(rx_fill_next);
                    tx_free_next    = udbrb_pkg::OUT_CNT_W'(
                        udbrb_pkg::CNT_W'(udbrb_pkg::QUEUE_DEPTH) - tx_fill_next);
                    err_next        = flags_next;
                    out_valid_next  = !pop_hit;
                    state_next      = pop_hit ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                // Capture the RAM word and present the result.
                data_out_next  = sel_tx_reg ? tx_rdata : rx_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rx_head_reg   <= '0;
            rx_fill_reg   <= '0;
            tx_head_reg   <= '0;
            tx_fill_reg   <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rx_head_reg   <= rx_head_next;
            rx_fill_reg   <= rx_fill_next;
            tx_head_reg   <= tx_head_next;
            tx_fill_reg   <= tx_fill_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        sel_tx_reg     <= sel_tx_next;
        data_out_reg   <= data_out_next;
        data_valid_reg <= data_valid_next;
        accepted_reg   <= accepted_next;
        rx_count_reg   <= rx_count_next;
        tx_free_reg    <= tx_free_next;
        err_reg        <= err_next;
    end

    udbrb_ram #(
        .WIDTH (udbrb_pkg::BYTE_W),
        .DEPTH (udbrb_pkg::QUEUE_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .en    (rx_en),
        .we    (rx_we),
        .addr  (rx_addr),
        .wdata (req.data_byte),
        .rdata (rx_rdata)
    );

    udbrb_ram #(
        .WIDTH (udbrb_pkg::BYTE_W),
        .DEPTH (udbrb_pkg::QUEUE_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .en    (tx_en),
        .we    (tx_we),
        .addr  (tx_addr),
        .wdata (req.data_byte),
        .rdata (tx_rdata)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.data_out    = data_out_reg;
    assign rsp.data_valid  = data_valid_reg;
    assign rsp.accepted    = accepted_reg;
    assign rsp.rx_count    = rx_count_reg;
    assign rsp.tx_free     = tx_free_reg;
    assign rsp.error_flags = err_reg;

    // No request is taken while a RAM read is outstanding.
    `UDBRB_ASSERT_NOW(a_no_accept_in_read, clk, rst_n, state_reg == S_READ, !req.ready)
    // A pop that hits data goes to the read cycle.
    `UDBRB_ASSERT_NEXT(a_pop_reads, clk, rst_n, accept && pop_hit, state_reg == S_READ)
    // The read cycle always presents a popped byte.
    `UDBRB_ASSERT_NEXT(a_read_presents, clk, rst_n, state_reg == S_READ,
        out_valid_reg && data_valid_reg)
    // Fill counts never exceed the queue depth.
    `UDBRB_ASSERT_NOW(a_fill_bounded, clk, rst_n, 1'b1,
        (rx_fill_reg <= udbrb_pkg::CNT_W'(udbrb_pkg::QUEUE_DEPTH)) &&
        (tx_fill_reg <= udbrb_pkg::CNT_W'(udbrb_pkg::QUEUE_DEPTH)))

endmodule

`default_nettype wire

>>> test/udbrb_ring_checker.sv
// Checker for the dual byte ring buffer: predicts every result from the
// accepted requests and compares it with what the block returns.
// Depends on udbrb_pkg and the udbrb_in_if / udbrb_out_if channel interfaces.
`default_nettype none

module udbrb_ring_checker
    import udbrb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    udbrb_in_if       req,
    udbrb_out_if      rsp,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0]    data_out;
        logic                 data_valid;
        logic                 accepted;
        logic [OUT_CNT_W-1:0] rx_count;
        logic [OUT_CNT_W-1:0] tx_free;
        logic [FLAGS_W-1:0]   error_flags;
    } ring_result_t;

    // Predicted queue state
    logic [BYTE_W-1:0]  rx_bytes [QUEUE_DEPTH];
    logic [BYTE_W-1:0]  tx_bytes [QUEUE_DEPTH];
    int unsigned        rx_head;
    int unsigned        rx_fill;
    int unsigned        tx_head;
    int unsigned        tx_fill;
    logic [FLAGS_W-1:0] sticky_flags;

    ring_result_t expected_results [$];

    // Apply one request to the predicted queues and return its status result
    function automatic ring_result_t predict_ring_result(
        logic [MODE_W-1:0] mode,
        logic [BYTE_W-1:0] byte_val,
        logic              ovr
    );
        ring_result_t r;
        r = '0;
        case (mode)
            MODE_LINE_RX:
            begin
                if (ovr)
                begin
                    sticky_flags[FLAG_LINE_OVR] = 1'b1;
                end
                if (rx_fill >= QUEUE_DEPTH)
                begin
                    sticky_flags[FLAG_QUEUE_OVR] = 1'b1;
                end
                else
                begin
                    rx_bytes[PTR_W'((rx_head + rx_fill) % QUEUE_DEPTH)] = byte_val;
                    rx_fill++;
                    r.accepted = 1'b1;
                end
            end
            MODE_HOST_RD:
            begin
                if (rx_fill > 0)
                begin
                    r.data_out   = rx_bytes[PTR_W'(rx_head)];
                    r.data_valid = 1'b1;
                    rx_head      = (rx_head + 1) % QUEUE_DEPTH;
                    rx_fill--;
                end
            end
            MODE_HOST_WR:
            begin
                if (tx_fill < QUEUE_DEPTH)
                begin
                    tx_bytes[PTR_W'((tx_head + tx_fill) % QUEUE_DEPTH)] = byte_val;
                    tx_fill++;
                    r.accepted = 1'b1;
                end
            end
            MODE_LINE_TX:
            begin
                if (tx_fill > 0)
                begin
                    r.data_out   = tx_bytes[PTR_W'(tx_head)];
                    r.data_valid = 1'b1;
                    tx_head      = (tx_head + 1) % QUEUE_DEPTH;
                    tx_fill--;
                end
            end
            MODE_FLUSH_RX:
            begin
                rx_head = 0;
                rx_fill = 0;
            end
            MODE_REINIT:
            begin
                rx_head      = 0;
                rx_fill      = 0;
                tx_head      = 0;
                tx_fill      = 0;
                sticky_flags = '0;
            end
            default:
            begin
                // spare codes only report status
            end
        endcase
        r.rx_count    = OUT_CNT_W'(rx_fill);
        r.tx_free     = OUT_CNT_W'(QUEUE_DEPTH - tx_fill);
        r.error_flags = sticky_flags;
        return r;
    endfunction

    // Match results against the oldest prediction, then record new requests
    always @(posedge clk or negedge rst_n)
    begin : watch
        ring_result_t got;
        ring_result_t want;
        int           errs;
        if (!rst_n)
        begin
            rx_head      = 0;
            rx_fill      = 0;
            tx_head      = 0;
            tx_fill      = 0;
            sticky_flags = '0;
            expected_results.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            errs = fail_count;
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.data_out, rsp.data_valid, rsp.accepted,
                       rsp.rx_count, rsp.tx_free, rsp.error_flags};
                if (expected_results.size() == 0)
                begin
                    errs++;
                    if (errs <= REPORT_LIMIT)
                    begin
                        $display("unexpected result: data %02h/%0b acc %0b rx %0d free %0d flags %02b",
                                 got.data_out, got.data_valid, got.accepted,
                                 got.rx_count, got.tx_free, got.error_flags);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        if (errs <= REPORT_LIMIT)
                        begin
                            $display("result mismatch: expected data %02h/%0b acc %0b rx %0d free %0d flags %02b",
                                     want.data_out, want.data_valid, want.accepted,
                                     want.rx_count, want.tx_free, want.error_flags);
                            $display("                 actual   data %02h/%0b acc %0b rx %0d free %0d flags %02b",
                                     got.data_out, got.data_valid, got.accepted,
                                     got.rx_count, got.tx_free, got.error_flags);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_results.push_back(
                    predict_ring_result(req.mode, req.data_byte, req.line_overrun));
            end
            fail_count    <= errs;
            pending_count <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

>>> test/uart_dual_byte_ring_buffer_test.sv
// Top of the ring buffer test: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Instantiates the block and the checker.
// Depends on udbrb_pkg, the channel interfaces and udbrb_ring_checker.
`default_nettype none

module uart_dual_byte_ring_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import udbrb_pkg::*;

    localparam realtime HALF_PERIOD = 1ns;

    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;
    localparam int FLOOD_ROUNDS = 262;
    localparam int MIXED_ITEMS  = 15;
    localparam int CALM_ITEMS   = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic throttle;
    int   fail_count;
    int   pending_count;

    udbrb_in_if  req_ch ();
    udbrb_out_if rsp_ch ();

    uart_dual_byte_ring_buffer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    udbrb_ring_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Offer one request, with an optional idle burst first; hold until transfer
    task automatic send_item(
        input logic [MODE_W-1:0] mode,
        input logic [BYTE_W-1:0] byte_val,
        input logic              ovr
    );
        if (throttle && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.data_byte    <= byte_val;
        req_ch.line_overrun <= ovr;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Weighted mode mix for the free-running part
    function automatic logic [MODE_W-1:0] pick_mixed_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return MODE_LINE_RX;
        else if (r < 50)
            return MODE_HOST_RD;
        else if (r < 70)
            return MODE_HOST_WR;
        else if (r < 90)
            return MODE_LINE_TX;
        else if (r < 94)
            return MODE_FLUSH_RX;
        else if (r < 97)
            return MODE_REINIT;
        else if (r < 99)
            return MODE_SPARE_6;
        else
            return MODE_SPARE_7;
    endfunction

    // Send one random item of the given mode; rare overrun marks on line bytes
    task automatic send_random(input logic [MODE_W-1:0] mode);
        logic ovr;
        if (mode == MODE_LINE_RX)
            ovr = ($urandom_range(0, 15) == 0);
        else
            ovr = 1'($urandom_range(0, 1));
        send_item(mode, BYTE_W'($urandom_range(0, 255)), ovr);
    endtask

    // Throttle the result side in random bursts while throttling is on
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!throttle)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // End the run when no transfer happens for too long
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        rst_n               <= 1'b0;
        throttle            <= 1'b1;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_LINE_RX;
        req_ch.data_byte    <= '0;
        req_ch.line_overrun <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops of empty queues
        send_item(MODE_HOST_RD, 8'h00, 1'b0);
        send_item(MODE_LINE_TX, 8'hFF, 1'b0);
        // Line bytes at the extremes, one marked with a line overrun
        send_item(MODE_LINE_RX, 8'h00, 1'b0);
        send_item(MODE_LINE_RX, 8'hFF, 1'b1);
        send_item(MODE_LINE_RX, 8'hA5, 1'b0);
        send_item(MODE_HOST_RD, 8'h5A, 1'b1);
        // Host bytes at the extremes, then a line pop
        send_item(MODE_HOST_WR, 8'hFF, 1'b0);
        send_item(MODE_HOST_WR, 8'h00, 1'b1);
        send_item(MODE_LINE_TX, 8'h00, 1'b0);
        // Flush with bytes waiting; overrun mark outside line mode is ignored
        send_item(MODE_FLUSH_RX, 8'h81, 1'b1);
        send_item(MODE_HOST_RD, 8'h7E, 1'b0);
        // Spare codes leave state alone
        send_item(MODE_SPARE_6, 8'hFF, 1'b1);
        send_item(MODE_SPARE_7, 8'h00, 1'b1);
        // Reinit with transmit bytes held and flags set
        send_item(MODE_REINIT, 8'h3C, 1'b1);
        send_item(MODE_LINE_TX, 8'hC3, 1'b0);
        send_item(MODE_HOST_RD, 8'h00, 1'b0);
        // Back-to-back pushes and pops on both queues
        send_item(MODE_LINE_RX, 8'h11, 1'b0);
        send_item(MODE_LINE_RX, 8'h22, 1'b0);
        send_item(MODE_HOST_RD, 8'h00, 1'b0);
        send_item(MODE_HOST_RD, 8'h00, 1'b0);
        send_item(MODE_HOST_WR, 8'h33, 1'b0);
        send_item(MODE_HOST_WR, 8'h44, 1'b0);
        send_item(MODE_LINE_TX, 8'h00, 1'b0);
        send_item(MODE_LINE_TX, 8'h00, 1'b0);
        send_item(MODE_REINIT, 8'h00, 1'b0);

        // Fill both queues past full, with a few stray pops and spare codes
        for (int i = 0; i < FLOOD_ROUNDS; i++)
        begin
            send_random(MODE_LINE_RX);
            send_random(MODE_HOST_WR);
            if ($urandom_range(0, 23) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: send_random(MODE_HOST_RD);
                    1: send_random(MODE_LINE_TX);
                    2: send_random(MODE_SPARE_6);
                    default: send_random(MODE_SPARE_7);
                endcase
            end
        end

        // Mixed traffic from full queues, wrapping the ring indexes
        for (int i = 0; i < MIXED_ITEMS; i++)
        begin
            send_random(pick_mixed_mode());
        end

        // Last stretch at full rate on both sides
        throttle <= 1'b0;
        for (int i = 0; i < CALM_ITEMS; i++)
        begin
            send_random(pick_mixed_mode());
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding results, then let the pipe settle
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
